/* design/lzw12_pkg.sv */
// lzw12_pkg: shared constants, types and the hash function of the 12-bit lzw compressor
// used by lzw12_outq and lzw_compressor_12bit_core; depends on nothing
package lzw12_pkg;

  localparam int unsigned TABLE_SIZE = 4096;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned KEY_W      = IDX_W + 8;
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned FIRST_FREE = 256;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // one hash table slot: the (prefix, byte) key and the code given to it
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] code;
  } slot_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } res_t;

  // results handed to the output queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } oq_push_t;

  function automatic logic [IDX_W-1:0] pair_hash(input logic [IDX_W-1:0] prefix,
                                                 input logic [7:0] b);
    logic [IDX_W-1:0] h;
    h = prefix ^ (IDX_W'(b) << (IDX_W - 8));
    return h;
  endfunction

endpackage

/* design/lzw_compressor_12bit_core.sv */
// lzw_compressor_12bit_core: lzw compressor top level with hashed dictionary lookup
// depends on lzw12_pkg, lzw12_ram and lzw12_outq
//
// usage: bytes enter on the input channel (opcode_i = data, data_byte_i) and 12-bit codes
// leave on the output channel (code_o, last_o). opcode_i = end flushes the pending prefix
// with last_o set and returns the block to its reset state.
// a transaction moves when valid is high and stall is low at a rising edge.
// the dictionary lives in a hash table memory (TABLE_SIZE slots, linear probing), read one
// slot per cycle with registered read data; the probe loop sets the rate.
// a hit goes from the probe state back to idle, a miss writes the new entry and moves to
// the emit state, and each colliding slot adds a probe; the first byte after start only
// sets the prefix. results enter a two-entry output queue from the emit state once it has
// room; a stalled receiver only blocks new items once the queue lacks room for their results.
// after reset, after end of data and after each dictionary clear the block sweeps the
// table to mark all TABLE_SIZE slots empty, with in_stall_o high.
module lzw_compressor_12bit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lzw12_pkg::CODE_W-1:0]  code_o,
  output logic                          last_o
);
  import lzw12_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam logic [IDX_W-1:0] FULL_CODE = IDX_W'(TABLE_SIZE - 1);

  logic [1:0]       state_q, state_d;
  logic             started_q, started_d;
  logic [IDX_W-1:0] prefix_q, prefix_d;
  logic [IDX_W-1:0] next_code_q, next_code_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [7:0]       byte_q, byte_d;
  oq_push_t         pend_q, pend_d;
  logic             clr_after_q, clr_after_d;

  logic             in_acc;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr, nc_inc;
  slot_t            ram_wdata, rd;
  logic [$bits(slot_t)-1:0] rd_raw;
  oq_push_t         push;
  logic [1:0]       oq_cnt;
  logic             room;
  res_t             res;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd         = slot_t'(rd_raw);
  assign nc_inc     = next_code_q + IDX_W'(1);
  assign room       = (pend_q.n == 2'd2) ? (oq_cnt == 2'd0) : (oq_cnt != 2'd2);

  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    prefix_d    = prefix_q;
    next_code_d = next_code_q;
    clr_cnt_d   = clr_cnt_q;
    idx_d       = idx_q;
    key_d       = key_q;
    byte_d      = byte_q;
    pend_d      = pend_q;
    clr_after_d = clr_after_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;
    ram_raddr   = idx_q + IDX_W'(1);
    push        = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == FULL_CODE) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = pair_hash(prefix_q, data_byte_i);
        if (in_acc) begin
          if (opcode_i == OP_END) begin
            started_d   = 1'b0;
            prefix_d    = '0;
            next_code_d = IDX_W'(FIRST_FREE);
            clr_cnt_d   = '0;
            if (started_q) begin
              pend_d.n    = 2'd1;
              pend_d.r0   = '{code: CODE_W'(prefix_q), last: 1'b1};
              clr_after_d = 1'b1;
              state_d     = S_EMIT;
            end else begin
              state_d = S_CLEAR;
            end
          end else if (!started_q) begin
            started_d = 1'b1;
            prefix_d  = IDX_W'(data_byte_i);
          end else begin
            key_d   = {prefix_q, data_byte_i};
            byte_d  = data_byte_i;
            idx_d   = pair_hash(prefix_q, data_byte_i);
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (rd.valid && rd.key == key_q) begin
          prefix_d = rd.code;
          state_d  = S_IDLE;
        end else if (rd.valid) begin
          // collision, try the next slot
          idx_d = idx_q + IDX_W'(1);
        end else begin
          ram_we      = 1'b1;
          ram_wdata   = '{valid: 1'b1, key: key_q, code: next_code_q};
          pend_d.r0   = '{code: CODE_W'(prefix_q), last: 1'b1};
          pend_d.r1   = '{code: CODE_W'(TABLE_SIZE - 1), last: 1'b1};
          prefix_d    = IDX_W'(byte_q);
          clr_cnt_d   = '0;
          state_d     = S_EMIT;
          if (nc_inc == FULL_CODE) begin
            pend_d.n     = 2'd2;
            pend_d.r0.last = 1'b0;
            next_code_d  = IDX_W'(FIRST_FREE);
            clr_after_d  = 1'b1;
          end else begin
            pend_d.n    = 2'd1;
            next_code_d = nc_inc;
            clr_after_d = 1'b0;
          end
        end
      end
      S_EMIT: begin
        if (room) begin
          push    = pend_q;
          state_d = clr_after_q ? S_CLEAR : S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      started_q   <= 1'b0;
      prefix_q    <= '0;
      next_code_q <= IDX_W'(FIRST_FREE);
      clr_cnt_q   <= '0;
      clr_after_q <= 1'b0;
      pend_q      <= '0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      prefix_q    <= prefix_d;
      next_code_q <= next_code_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_after_q <= clr_after_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    key_q  <= key_d;
    byte_q <= byte_d;
  end

  lzw12_ram #(
    .Width($bits(slot_t)),
    .Depth(TABLE_SIZE)
  ) u_dict (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd_raw)
  );

  lzw12_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .cnt_o      (oq_cnt),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign code_o = res.code;
  assign last_o = res.last;

  a_insert_only_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && ram_we) |-> !rd.valid) else $error("insert over a used slot");
  a_next_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_code_q >= IDX_W'(FIRST_FREE) && next_code_q < FULL_CODE)
    else $error("next code out of range");
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OP_END) |=> (!started_q && in_stall_o))
    else $error("end of data did not reset");
  a_emit_then_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && push.n == 2'd2) |=> state_q == S_CLEAR)
    else $error("dictionary full without clear");

endmodule

/* design/lzw12_ram.sv */
// lzw12_ram: generic one-write one-read memory with registered read data
// no dependencies
module lzw12_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lzw12_outq.sv */
// lzw12_outq: two-entry result queue between the lookup engine and the output channel
// depends on lzw12_pkg
module lzw12_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzw12_pkg::oq_push_t push_i,
  output logic [1:0]          cnt_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lzw12_pkg::res_t     res_o
);
  import lzw12_pkg::*;

  res_t       slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop = (cnt_q != 2'd0) && !out_stall_i;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
    case (push_i.n)
      2'd1: begin
        if (cnt_d == 2'd0) begin
          slot0_d = push_i.r0;
        end else begin
          slot1_d = push_i.r0;
        end
        cnt_d = cnt_d + 2'd1;
      end
      2'd2: begin
        slot0_d = push_i.r0;
        slot1_d = push_i.r1;
        cnt_d   = 2'd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign cnt_o       = cnt_q;
  assign out_valid_o = cnt_q != 2'd0;
  assign res_o       = slot0_q;

  a_pair_needs_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n == 2'd2 |-> cnt_q == 2'd0) else $error("pair pushed into non-empty queue");
  a_single_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n == 2'd1 |-> cnt_q != 2'd2) else $error("push into full queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

/* tb/tb_lzw_compressor_12bit_core.sv */
// tb_lzw_compressor_12bit_core: self-checking bench for the 12-bit lzw compressor core
// depends on lzw12_pkg and lzw_compressor_12bit_core; predicts codes with a keyed dictionary
module tb_lzw_compressor_12bit_core;
  import lzw12_pkg::*;

  localparam logic [CODE_W-1:0] CLEAR_CODE = CODE_W'(TABLE_SIZE - 1);
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    logic       op;
    logic [7:0] byte_val;
    bit         drain_hold;
  } byte_item_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              last;
  } code_res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, opcode_i;
  logic [7:0] data_byte_i;
  logic out_valid_o, out_stall_i, last_o;
  logic [CODE_W-1:0] code_o;

  byte_item_t pending_bytes[$];
  code_res_t  expected_codes[$];
  int errors, sent, issued, idle_cycles;
  bit stim_done;

  // predictor state
  bit                has_prefix;
  logic [CODE_W-1:0] prefix_code;
  int unsigned       free_code;
  logic [CODE_W-1:0] pair_dict[logic [19:0]];

  lzw_compressor_12bit_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .opcode_i(opcode_i), .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .code_o(code_o), .last_o(last_o)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic push_code(input logic [CODE_W-1:0] c, input logic l);
    code_res_t r;
    r.code = c;
    r.last = l;
    expected_codes.push_back(r);
  endtask

  task automatic clear_compressor();
    has_prefix = 0;
    prefix_code = '0;
    free_code = FIRST_FREE;
    pair_dict.delete();
  endtask

  task automatic compress_byte(input logic op, input logic [7:0] b);
    logic [19:0] pair_key;
    if (op == OP_END) begin
      if (has_prefix) push_code(prefix_code, 1'b1);
      clear_compressor();
    end else if (!has_prefix) begin
      has_prefix = 1;
      prefix_code = CODE_W'(b);
    end else begin
      pair_key = {prefix_code, b};
      if (pair_dict.exists(pair_key)) begin
        prefix_code = pair_dict[pair_key];
      end else begin
        pair_dict[pair_key] = CODE_W'(free_code);
        free_code++;
        if (free_code >= TABLE_SIZE - 1) begin
          push_code(prefix_code, 1'b0);
          push_code(CLEAR_CODE, 1'b1);
          free_code = FIRST_FREE;
          pair_dict.delete();
        end else begin
          push_code(prefix_code, 1'b1);
        end
        prefix_code = CODE_W'(b);
      end
    end
  endtask

  task automatic add_byte(input logic op, input logic [7:0] b);
    byte_item_t it;
    it.op = op;
    it.byte_val = b;
    it.drain_hold = 0;
    pending_bytes.push_back(it);
  endtask

  task automatic add_hold();
    byte_item_t it;
    it.op = OP_DATA;
    it.byte_val = '0;
    it.drain_hold = 1;
    pending_bytes.push_back(it);
  endtask

  // idle and stall odds per phase, cycling with the item count
  function automatic int in_idle_pct();
    case ((sent / 250) % 4)
      1: in_idle_pct = 66;
      3: in_idle_pct = 9;
      default: in_idle_pct = 0;
    endcase
  endfunction

  function automatic int out_stall_pct();
    case ((sent / 250) % 4)
      2: out_stall_pct = 66;
      3: out_stall_pct = 9;
      default: out_stall_pct = 0;
    endcase
  endfunction

  // driver: inputs change on the falling edge; the held transaction is done once
  // the monitor has counted it
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_stall_pct());
      if (!in_valid_i || sent == issued) begin
        if (pending_bytes.size() > 0 && pending_bytes[0].drain_hold) begin
          in_valid_i <= 1'b0;
          if (expected_codes.size() == 0) void'(pending_bytes.pop_front());
        end else if (pending_bytes.size() > 0 && $urandom_range(99) >= in_idle_pct()) begin
          in_valid_i <= 1'b1;
          opcode_i <= pending_bytes[0].op;
          data_byte_i <= pending_bytes[0].byte_val;
          void'(pending_bytes.pop_front());
          issued++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: accepts, predicts and checks on the rising edge
  always @(posedge clk_i) begin
    code_res_t want;
    bit moved;
    moved = 0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      compress_byte(opcode_i, data_byte_i);
      sent++;
      moved = 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1;
      if (expected_codes.size() == 0) begin
        report($sformatf("unexpected code %0d last %0b", code_o, last_o));
      end else begin
        want = expected_codes.pop_front();
        if (code_o !== want.code)
          report($sformatf("code %0d, predicted %0d", code_o, want.code));
        if (last_o !== want.last)
          report($sformatf("last %0b, predicted %0b", last_o, want.last));
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int run_len, alpha;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    opcode_i = OP_DATA;
    data_byte_i = '0;
    errors = 0;
    sent = 0;
    issued = 0;
    idle_cycles = 0;
    clear_compressor();

    // end with nothing pending, single byte flush, repeats that hit, byte extremes
    add_byte(OP_END, 8'h00);
    add_byte(OP_DATA, 8'h00);
    add_byte(OP_END, 8'hff);
    repeat (5) add_byte(OP_DATA, 8'h00);
    repeat (4) add_byte(OP_DATA, 8'hff);
    add_byte(OP_DATA, 8'haa);
    add_byte(OP_DATA, 8'h55);
    add_byte(OP_DATA, 8'haa);
    add_byte(OP_DATA, 8'h55);
    add_byte(OP_END, 8'h00);
    add_byte(OP_END, 8'h00);
    add_byte(OP_DATA, 8'h80);
    add_byte(OP_END, 8'h7f);
    add_hold();

    // random streams, mostly small alphabets so dictionary hits happen
    while (pending_bytes.size() < 900) begin
      run_len = $urandom_range(1, 60);
      alpha = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 7);
      repeat (run_len) begin
        if ($urandom_range(49) == 0) add_byte(OP_END, 8'($urandom));
        else if (alpha == 255) add_byte(OP_DATA, 8'($urandom));
        else add_byte(OP_DATA, 8'($urandom_range(alpha)) ^ 8'hc3);
      end
      add_byte(OP_END, 8'($urandom));
    end
    add_hold();

    // longer stream of wide-range bytes to grow the dictionary
    repeat (300) add_byte(OP_DATA, 8'($urandom));
    add_byte(OP_END, 8'h00);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_bytes.size() == 0 && !in_valid_i && expected_codes.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/lzw12_pkg.sv
design/lzw12_ram.sv
design/lzw12_outq.sv
design/lzw_compressor_12bit_core.sv
tb/tb_lzw_compressor_12bit_core.sv
